// File: sv/crsp_pkg.sv
package crsp_pkg;

	localparam int TIME_W  = 64;
	localparam int IVL_W   = 48;
	localparam int FB_W    = 14;
	localparam int CNT_FW  = 9;
	localparam int EXC_W   = 32;
	localparam int DATA_W  = 64;
	localparam int ADDR_W  = 5;

	localparam logic [IVL_W-1:0] SLOT_IVL_RST = IVL_W'(1);
	localparam logic [FB_W-1:0]  FRAME_B_RST  = FB_W'(1500);

	typedef enum logic [1:0] {
		REG_SLOT_IVL  = 2'd0,
		REG_FRAME_B   = 2'd1,
		REG_NO_PAD    = 2'd2,
		REG_SNAP_IVL  = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_CAP,
		ST_APPLY,
		ST_BYTES,
		ST_DONE
	} pacer_state_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_now;
		logic [CNT_FW-1:0] user_frames_ready;
		logic [CNT_FW-1:0] pad_frames_ready;
	} poll_item_t;

	typedef struct packed {
		logic              too_early;
		logic [CNT_FW-1:0] slots_due;
		logic [CNT_FW-1:0] user_sent;
		logic [CNT_FW-1:0] pads_sent;
		logic [CNT_FW-1:0] pads_skipped;
		logic [CNT_FW-1:0] pad_underrun;
		logic [EXC_W-1:0]  held_excess;
		logic              slipped;
		logic              snapshot_taken;
		logic [TIME_W-1:0] total_packets;
		logic [TIME_W-1:0] total_bytes;
		logic [TIME_W-1:0] total_dues;
	} result_item_t;

endpackage

// File: sv/constant_rate_slot_pacer_unit.sv
// Sequence: a poll that is on time passes CHECK, APPLY, BYTES and DONE; an early poll goes
// from CHECK to DONE, and after a slip the 64-step divider counts the slots in DIVIDE, then CAP.
// One poll at a time is taken; a result that waits for result_ready holds the sequencer,
// and poll_ready is high only while it idles.
// Reset (arst_n low, asynchronous) clears the due time, the snapshot time and all totals,
// and returns the registers to interval 1, frame size 1500, padding on, snapshots at 0.
module constant_rate_slot_pacer_unit
	import crsp_pkg::*;
#(
	parameter int MAX_SLOTS = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              poll_valid,
	output logic              poll_ready,
	input  poll_item_t        poll,
	output logic              result_valid,
	input  logic              result_ready,
	output result_item_t      result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	// A slot count never exceeds MAX_SLOTS, so this width holds every count.
	localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
	localparam int PROD_W = SLOT_W + FB_W;
	// Readiness counts and slot counts are compared at the wider of their two widths.
	localparam int CMP_W  = (SLOT_W > CNT_FW) ? SLOT_W : CNT_FW;

	// Configuration registers.
	logic [IVL_W-1:0]  slot_ivl_q;
	logic [FB_W-1:0]   frame_b_q;
	logic              no_pad_q;
	logic [IVL_W-1:0]  snap_ivl_q;
	cfg_reg_t          reg_sel;
	logic              cfg_wr;

	// Pacing state.
	logic [TIME_W-1:0] next_due_q;
	logic [TIME_W-1:0] next_snap_q;
	logic [TIME_W-1:0] pkt_total_q;
	logic [TIME_W-1:0] byte_total_q;
	logic [TIME_W-1:0] due_total_q;

	// Sequencer and per-poll working registers.
	pacer_state_t      state_q;
	pacer_state_t      state_nx;
	poll_item_t        poll_q;
	logic              early_q;
	logic              slip_q;
	logic              snap_q;
	logic [SLOT_W-1:0] slots_q;
	logic [EXC_W-1:0]  excess_q;
	logic [SLOT_W-1:0] usent_q;
	logic [SLOT_W-1:0] psent_q;
	logic [SLOT_W-1:0] pskip_q;
	logic [SLOT_W-1:0] punder_q;
	logic [PROD_W-1:0] prod_q;

	// Output register.
	logic              result_valid_q;
	result_item_t      result_q;
	result_item_t      result_nx;

	// Combinational helpers.
	logic [IVL_W-1:0]  ivl;
	logic [TIME_W-1:0] delta;
	logic              too_early;
	logic              need_div;
	logic              div_start;
	logic              div_done;
	logic [TIME_W-1:0] quo;
	logic              over_cap;
	logic [TIME_W-1:0] excess_full;
	logic [CMP_W-1:0]  user_w;
	logic [CMP_W-1:0]  pad_w;
	logic [CMP_W-1:0]  slots_w;
	logic [CMP_W-1:0]  remain_w;
	logic [SLOT_W-1:0] usent;
	logic [SLOT_W-1:0] remain;
	logic [SLOT_W-1:0] psent;
	logic [SLOT_W-1:0] pskip;
	logic [SLOT_W-1:0] punder;
	logic [SLOT_W-1:0] sends;
	logic              load_result;

	// ------------------------------------------------------------------
	// Configuration port. Writes complete in the access phase; pready is
	// always high, so there are no wait states. Each register sits at an
	// eight-byte boundary, so the upper address bits select it.
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[4:3]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ivl_q <= SLOT_IVL_RST;
			frame_b_q  <= FRAME_B_RST;
			no_pad_q   <= 1'b0;
			snap_ivl_q <= '0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_SLOT_IVL: slot_ivl_q <= pwdata[IVL_W-1:0];
				REG_FRAME_B:  frame_b_q  <= pwdata[FB_W-1:0];
				REG_NO_PAD:   no_pad_q   <= pwdata[0];
				REG_SNAP_IVL: snap_ivl_q <= pwdata[IVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SLOT_IVL: prdata = DATA_W'(slot_ivl_q);
			REG_FRAME_B:  prdata = DATA_W'(frame_b_q);
			REG_NO_PAD:   prdata = DATA_W'(no_pad_q);
			REG_SNAP_IVL: prdata = DATA_W'(snap_ivl_q);
			default:      prdata = '0;
		endcase
	end

	// An interval of zero would stall the pacer for ever, so it behaves as one tick.
	assign ivl = (slot_ivl_q == '0) ? IVL_W'(1) : slot_ivl_q;

	// ------------------------------------------------------------------
	// Arithmetic that each step of the sequence needs.
	// ------------------------------------------------------------------

	// The poll is early when the signed distance to the due time is negative.
	assign delta     = poll_q.time_now - next_due_q;
	assign too_early = delta[TIME_W-1];
	assign need_div  = delta > TIME_W'(ivl);

	// After a slip the slot count is quotient + 1; it is over the cap once
	// the quotient reaches MAX_SLOTS, and the excess is then quotient + 1 - MAX_SLOTS.
	assign over_cap    = quo >= TIME_W'(MAX_SLOTS);
	assign excess_full = quo - TIME_W'(MAX_SLOTS - 1);

	// User frames take the slots first; the rest go to pads or are only counted.
	always_comb begin
		user_w   = CMP_W'(poll_q.user_frames_ready);
		pad_w    = CMP_W'(poll_q.pad_frames_ready);
		slots_w  = CMP_W'(slots_q);
		usent    = (user_w < slots_w) ? SLOT_W'(user_w) : slots_q;
		remain   = slots_q - usent;
		remain_w = CMP_W'(remain);
		if (no_pad_q) begin
			pskip  = remain;
			psent  = '0;
			punder = '0;
		end else begin
			pskip  = '0;
			psent  = (pad_w < remain_w) ? SLOT_W'(pad_w) : remain;
			punder = remain - psent;
		end
		sends = usent + psent;
	end

	// ------------------------------------------------------------------
	// Iterative divider: elapsed ticks over the slot interval.
	// ------------------------------------------------------------------
	crsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (delta),
		.divisor  (ivl),
		.done     (div_done),
		.quotient (quo)
	);

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_comb begin
		poll_ready  = (state_q == ST_IDLE);
		div_start   = (state_q == ST_CHECK) && !too_early && need_div;
		load_result = (state_q == ST_DONE) && (!result_valid_q || result_ready);
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (poll_valid) state_nx = ST_CHECK;
			end
			ST_CHECK: begin
				if (too_early)     state_nx = ST_DONE;
				else if (need_div) state_nx = ST_DIVIDE;
				else               state_nx = ST_APPLY;
			end
			ST_DIVIDE: begin
				if (div_done) state_nx = ST_CAP;
			end
			ST_CAP:   state_nx = ST_APPLY;
			ST_APPLY: state_nx = ST_BYTES;
			ST_BYTES: state_nx = ST_DONE;
			ST_DONE: begin
				if (load_result) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Working registers for the poll in flight.
	always_ff @(posedge clk) begin
		if (poll_valid && poll_ready) begin
			poll_q <= poll;
		end
		if (state_q == ST_CHECK) begin
			early_q  <= too_early;
			slip_q   <= need_div;
			slots_q  <= SLOT_W'(1);
			excess_q <= '0;
			snap_q   <= 1'b0;
		end
		if (state_q == ST_CAP) begin
			if (over_cap) begin
				slots_q  <= SLOT_W'(MAX_SLOTS);
				excess_q <= (excess_full[TIME_W-1:EXC_W] != '0) ? '1 : excess_full[EXC_W-1:0];
			end else begin
				slots_q  <= SLOT_W'(quo) + SLOT_W'(1);
			end
		end
		if (state_q == ST_APPLY) begin
			usent_q  <= usent;
			psent_q  <= psent;
			pskip_q  <= pskip;
			punder_q <= punder;
			prod_q   <= PROD_W'(sends) * PROD_W'(frame_b_q);
			snap_q   <= poll_q.time_now > next_snap_q;
		end
	end

	// Pacing state moves on once per poll that is not early.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_due_q   <= '0;
			next_snap_q  <= '0;
			pkt_total_q  <= '0;
			byte_total_q <= '0;
			due_total_q  <= '0;
		end else begin
			if (state_q == ST_APPLY) begin
				// After a slip the schedule restarts from the poll's own time.
				next_due_q  <= (slip_q ? poll_q.time_now : next_due_q) + TIME_W'(ivl);
				due_total_q <= due_total_q + TIME_W'(slots_q);
				pkt_total_q <= pkt_total_q + TIME_W'(sends);
				if (poll_q.time_now > next_snap_q) begin
					next_snap_q <= poll_q.time_now + TIME_W'(snap_ivl_q);
				end
			end
			if (state_q == ST_BYTES) begin
				byte_total_q <= byte_total_q + TIME_W'(prod_q);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result assembly and output register. An early poll reports only the
	// flag and the current totals.
	// ------------------------------------------------------------------
	always_comb begin
		result_nx                = '0;
		result_nx.too_early      = early_q;
		result_nx.total_packets  = pkt_total_q;
		result_nx.total_bytes    = byte_total_q;
		result_nx.total_dues     = due_total_q;
		if (!early_q) begin
			result_nx.slots_due      = CNT_FW'(slots_q);
			result_nx.user_sent      = CNT_FW'(usent_q);
			result_nx.pads_sent      = CNT_FW'(psent_q);
			result_nx.pads_skipped   = CNT_FW'(pskip_q);
			result_nx.pad_underrun   = CNT_FW'(punder_q);
			result_nx.held_excess    = excess_q;
			result_nx.slipped        = slip_q;
			result_nx.snapshot_taken = snap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_result) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q <= result_nx;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: sv/crsp_div.sv
module crsp_div
	import crsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [TIME_W-1:0] dividend,
	input  logic [IVL_W-1:0]  divisor,
	output logic              done,
	output logic [TIME_W-1:0] quotient
);

	localparam int CNT_W = $clog2(TIME_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TIME_W-1:0] quo_q;
	logic [IVL_W-1:0]  rem_q;
	logic [IVL_W-1:0]  dvs_q;
	logic [IVL_W:0]    rem_sh;
	logic              fits;
	logic [IVL_W:0]    rem_nx;

	// One quotient bit per cycle: shift the next dividend bit into the
	// partial remainder and subtract the divisor where it fits.
	always_comb begin
		rem_sh = {rem_q, quo_q[TIME_W-1]};
		fits   = rem_sh >= {1'b0, dvs_q};
		rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TIME_W-2:0], fits};
			rem_q <= rem_nx[IVL_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
